// ----- sv/assert_macros.svh -----
// Assertion macros shared by the note arbiter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MNPA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mnpa assertion failed");

// Next-cycle implication, disabled during reset.
`define MNPA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mnpa assertion failed");

`endif

// ----- sv/mnpa_pkg.sv -----
// Types and constants of the monophonic note arbiter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mnpa_pkg;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_SET_MUTE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] channel;
    logic [6:0] note;
    logic       mute_value;
  } req_t;

  typedef struct packed {
    logic [13:0] tone_hz;
    logic        after_gap;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
  } pair_t;

  localparam logic [3:0] SKIP_RESET = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OFF_SCAN,
    ST_ARB_SCAN,
    ST_SIL_LAST,
    ST_SIL_MORE,
    ST_TONE_GAP,
    ST_TONE
  } state_t;

  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_MATCH,
    SCAN_MAX
  } scan_op_t;

  typedef enum logic [1:0] {
    OUT_SIL_LAST,
    OUT_SIL_MORE,
    OUT_TONE_GAP,
    OUT_TONE
  } out_kind_t;

  typedef struct packed {
    logic      ev_load;
    logic      scan_rst;
    scan_op_t  scan_op;
    logic      push;
    logic      count_dec;
    logic      count_clr;
    logic      sound_clr;
    logic      sound_load;
    logic      mute_load;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       skip_hit;
    logic       full;
    logic       scan_done;
    logic       found;
    logic       empty;
    logic       same_winner;
    logic       sound_valid;
    logic       mute_value;
    logic       out_free;
  } status_t;

  localparam logic [13:0] FREQ_TABLE [128] = '{
    14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12,
    14'd13, 14'd14, 14'd15, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
    14'd21, 14'd22, 14'd23, 14'd24, 14'd26, 14'd28, 14'd29, 14'd31,
    14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44, 14'd46, 14'd49,
    14'd52, 14'd55, 14'd58, 14'd62, 14'd65, 14'd69, 14'd73, 14'd78,
    14'd82, 14'd87, 14'd92, 14'd98, 14'd104, 14'd110, 14'd117, 14'd123,
    14'd131, 14'd139, 14'd147, 14'd156, 14'd165, 14'd175, 14'd185, 14'd196,
    14'd208, 14'd220, 14'd233, 14'd247, 14'd262, 14'd277, 14'd294, 14'd311,
    14'd330, 14'd349, 14'd370, 14'd392, 14'd415, 14'd440, 14'd466, 14'd494,
    14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd740, 14'd784,
    14'd831, 14'd880, 14'd932, 14'd988, 14'd1047, 14'd1109, 14'd1175, 14'd1245,
    14'd1319, 14'd1397, 14'd1480, 14'd1568, 14'd1661, 14'd1760, 14'd1865, 14'd1976,
    14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2794, 14'd2960, 14'd3136,
    14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4435, 14'd4699, 14'd4978,
    14'd5274, 14'd5588, 14'd5920, 14'd6272, 14'd6645, 14'd7040, 14'd7459, 14'd7902,
    14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11840, 14'd12544
  };

endpackage

`default_nettype wire

// ----- sv/mono_note_priority_arbiter.sv -----
// Monophonic highest-note arbiter for a square-wave buzzer voice.
// Channels: req (valid/ready) carries one note request: note on, note off,
// all notes off or set mute. rsp (valid/ready) carries tone writes, each
// with a gap flag and a last flag on the final write of a request.
// cfg_we writes the skipped channel (reset 9) whenever it is high.
// The block works on one request at a time. A note-on (unless it is on the
// skipped channel, which drops it) or a note-off walks the held-note memory,
// one entry per cycle: a note-off searches and closes the gap in one pass,
// then the maximum search runs. All notes off and set mute need no walk.
// After reset nothing is held, nothing sounds and the voice is muted; no
// clearing pass is needed.
// A stalled receiver holds the result register; the controller then waits
// in its write state, and a new request is taken once the last result of
// the current one is loaded into the result register.
// Depends on mnpa_pkg, mnpa_ctrl and mnpa_datapath.
`default_nettype none

module mono_note_priority_arbiter #(
  parameter int HELD_DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [3:0]     cfg_wdata,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire mnpa_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output mnpa_pkg::rsp_t      rsp
);

  mnpa_pkg::cmd_t    cmd;
  mnpa_pkg::status_t sts;

  mnpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnpa_datapath #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- sv/mnpa_datapath.sv -----
// Datapath of the note arbiter: held-note memory, scan pipeline, voice state, result register.
// Depends on mnpa_pkg and assert_macros.svh; driven by mnpa_ctrl commands.
`default_nettype none
`include "assert_macros.svh"

module mnpa_datapath #(
  parameter int HELD_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [3:0]       cfg_wdata,
  input  wire mnpa_pkg::req_t   req,
  output mnpa_pkg::rsp_t        rsp,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  input  wire mnpa_pkg::cmd_t   cmd,
  output mnpa_pkg::status_t     sts
);

  localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);

  logic [3:0]      skipped_channel;
  mnpa_pkg::req_t  ev;
  mnpa_pkg::pair_t mem [HELD_DEPTH];
  mnpa_pkg::pair_t rd_data;
  mnpa_pkg::pair_t best;
  mnpa_pkg::pair_t sound;
  mnpa_pkg::pair_t key;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   cmp_idx;
  logic [CW-1:0]   cmp_prev;
  logic            cmp_live;
  logic            found;
  logic            sound_valid;
  logic            muted;
  logic            rd_ok;
  logic            match_scan;
  logic            max_scan;
  logic [13:0]     tone;

  assign key        = '{channel: ev.channel, note: ev.note};
  assign rd_ok      = rd_idx < count;
  assign match_scan = cmp_live && (cmd.scan_op == mnpa_pkg::SCAN_MATCH);
  assign max_scan   = cmp_live && (cmd.scan_op == mnpa_pkg::SCAN_MAX);
  assign cmp_prev   = cmp_idx - CW'(1);
  assign tone       = muted ? 14'd0 : mnpa_pkg::FREQ_TABLE[sound.note];

  always_ff @(posedge clk) begin
    if (rst) begin
      skipped_channel <= mnpa_pkg::SKIP_RESET;
      count           <= '0;
      rd_idx          <= '0;
      cmp_live        <= 1'b0;
      found           <= 1'b0;
      sound_valid     <= 1'b0;
      sound           <= '0;
      muted           <= 1'b1;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        skipped_channel <= cfg_wdata;
      end
      if (cmd.scan_rst) begin
        rd_idx   <= '0;
        cmp_live <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.scan_op != mnpa_pkg::SCAN_NONE) begin
        cmp_live <= rd_ok;
        if (rd_ok) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (match_scan && !found && (rd_data == key)) begin
          found <= 1'b1;
        end
      end
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.sound_clr) begin
        sound_valid <= 1'b0;
        sound       <= '0;
      end else if (cmd.sound_load) begin
        sound_valid <= 1'b1;
        sound       <= best;
      end
      if (cmd.mute_load) begin
        muted <= ev.mute_value;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_load) begin
      ev <= req;
    end
    if (rd_ok) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
    cmp_idx <= rd_idx;
    if (cmd.push) begin
      mem[count[AW-1:0]] <= key;
    end else if (match_scan && found) begin
      mem[cmp_prev[AW-1:0]] <= rd_data;
    end
    if (max_scan && ((cmp_idx == '0) || (rd_data.note > best.note))) begin
      best <= rd_data;
    end
    if (cmd.out_load) begin
      case (cmd.out_kind)
        mnpa_pkg::OUT_SIL_LAST: rsp <= '{tone_hz: 14'd0, after_gap: 1'b0, last: 1'b1};
        mnpa_pkg::OUT_SIL_MORE: rsp <= '{tone_hz: 14'd0, after_gap: 1'b0, last: 1'b0};
        mnpa_pkg::OUT_TONE_GAP: rsp <= '{tone_hz: tone, after_gap: 1'b1, last: 1'b1};
        mnpa_pkg::OUT_TONE:     rsp <= '{tone_hz: tone, after_gap: 1'b0, last: 1'b1};
        default:                rsp <= '{tone_hz: 14'd0, after_gap: 1'b0, last: 1'b1};
      endcase
    end
  end

  always_comb begin
    sts.op          = ev.opcode;
    sts.skip_hit    = ev.channel == skipped_channel;
    sts.full        = count == DEPTH_C;
    sts.scan_done   = !cmp_live && !rd_ok;
    sts.found       = found;
    sts.empty       = count == '0;
    sts.same_winner = sound_valid && (best == sound);
    sts.sound_valid = sound_valid;
    sts.mute_value  = ev.mute_value;
    sts.out_free    = !rsp_valid || rsp_ready;
  end

  `MNPA_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= DEPTH_C)
  `MNPA_ASSERT_IMP(a_cmp_in_list, clk, rst, cmp_live, cmp_idx < count)
  `MNPA_ASSERT_NXT(a_load_sets_valid, clk, rst, cmd.out_load, rsp_valid)

endmodule

`default_nettype wire

// ----- sv/mnpa_ctrl.sv -----
// Controller state machine of the note arbiter: sequences dispatch, scans and result writes.
// Depends on mnpa_pkg and assert_macros.svh; commands mnpa_datapath.
`default_nettype none
`include "assert_macros.svh"

module mnpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire mnpa_pkg::status_t sts,
  output mnpa_pkg::cmd_t         cmd
);

  mnpa_pkg::state_t state;
  mnpa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.scan_op  = mnpa_pkg::SCAN_NONE;
    cmd.out_kind = mnpa_pkg::OUT_SIL_LAST;
    case (state)
      mnpa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.ev_load  = 1'b1;
          cmd.scan_rst = 1'b1;
          state_next   = mnpa_pkg::ST_DISPATCH;
        end
      end
      mnpa_pkg::ST_DISPATCH: begin
        case (sts.op)
          mnpa_pkg::OP_NOTE_ON: begin
            if (sts.skip_hit) begin
              state_next = mnpa_pkg::ST_IDLE;
            end else begin
              cmd.push   = !sts.full;
              state_next = mnpa_pkg::ST_ARB_SCAN;
            end
          end
          mnpa_pkg::OP_NOTE_OFF: begin
            state_next = mnpa_pkg::ST_OFF_SCAN;
          end
          mnpa_pkg::OP_ALL_OFF: begin
            cmd.count_clr = 1'b1;
            cmd.sound_clr = 1'b1;
            state_next    = mnpa_pkg::ST_SIL_LAST;
          end
          default: begin
            cmd.mute_load = 1'b1;
            if (sts.mute_value) begin
              state_next = mnpa_pkg::ST_SIL_LAST;
            end else if (sts.sound_valid) begin
              state_next = mnpa_pkg::ST_TONE;
            end else begin
              state_next = mnpa_pkg::ST_IDLE;
            end
          end
        endcase
      end
      mnpa_pkg::ST_OFF_SCAN: begin
        cmd.scan_op = mnpa_pkg::SCAN_MATCH;
        if (sts.scan_done) begin
          cmd.scan_rst  = 1'b1;
          cmd.count_dec = sts.found;
          state_next    = mnpa_pkg::ST_ARB_SCAN;
        end
      end
      mnpa_pkg::ST_ARB_SCAN: begin
        cmd.scan_op = mnpa_pkg::SCAN_MAX;
        if (sts.scan_done) begin
          if (sts.empty) begin
            if (sts.sound_valid) begin
              cmd.sound_clr = 1'b1;
              state_next    = mnpa_pkg::ST_SIL_LAST;
            end else begin
              state_next = mnpa_pkg::ST_IDLE;
            end
          end else if (sts.same_winner) begin
            state_next = mnpa_pkg::ST_IDLE;
          end else begin
            cmd.sound_load = 1'b1;
            state_next     = mnpa_pkg::ST_SIL_MORE;
          end
        end
      end
      mnpa_pkg::ST_SIL_LAST: begin
        cmd.out_kind = mnpa_pkg::OUT_SIL_LAST;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mnpa_pkg::ST_IDLE;
        end
      end
      mnpa_pkg::ST_SIL_MORE: begin
        cmd.out_kind = mnpa_pkg::OUT_SIL_MORE;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mnpa_pkg::ST_TONE_GAP;
        end
      end
      mnpa_pkg::ST_TONE_GAP: begin
        cmd.out_kind = mnpa_pkg::OUT_TONE_GAP;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mnpa_pkg::ST_IDLE;
        end
      end
      mnpa_pkg::ST_TONE: begin
        cmd.out_kind = mnpa_pkg::OUT_TONE;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mnpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mnpa_pkg::ST_IDLE;
      end
    endcase
  end

  `MNPA_ASSERT_IMP(a_gap_follows_silence, clk, rst, state == mnpa_pkg::ST_TONE_GAP,
                   $past(state) == mnpa_pkg::ST_SIL_MORE || $past(state) == mnpa_pkg::ST_TONE_GAP)
  `MNPA_ASSERT_IMP(a_tone_needs_voice, clk, rst,
                   cmd.out_load && cmd.out_kind == mnpa_pkg::OUT_TONE_GAP, sts.sound_valid)
  `MNPA_ASSERT_IMP(a_one_count_update, clk, rst, 1'b1,
                   $countones({cmd.push, cmd.count_dec, cmd.count_clr}) <= 1)

endmodule

`default_nettype wire
